/* rtl/core/assert_macros.svh */
// Assertion macros shared by the transposition table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/core/ttps_pkg.sv */
// Types and constants of the transposition table probe/store block.
`timescale 1ns / 1ps
`default_nettype none
package ttps_pkg;

    localparam int unsigned SCORE_W = 32;
    localparam int unsigned MOVE_W  = 24;
    localparam int unsigned ASK_W   = 4;

    typedef logic [1:0] t_bound;
    localparam t_bound BOUND_EXACT = 2'd0;
    localparam t_bound BOUND_LOWER = 2'd1;
    localparam t_bound BOUND_UPPER = 2'd2;

    typedef logic t_op;
    localparam t_op OP_PROBE = 1'b0;
    localparam t_op OP_STORE = 1'b1;

    typedef struct packed {
        logic                valid;
        t_bound              kind;
        logic [SCORE_W-1:0]  score;
        logic [MOVE_W-1:0]   move;
    } t_slot;

    localparam int unsigned SLOT_W = $bits(t_slot);

endpackage
`default_nettype wire

/* rtl/core/transposition_table_probe_store.sv */
// Top level of the transposition table probe/store block.
// Each beat is a probe or a store against a 2^INDEX_BITS-entry table with
// depth-preferred replacement; every beat yields exactly one result beat.
// Sustained rate is one beat per cycle while the output is not stalled and
// no clearing pass runs: the table is read at acceptance, the entry is
// evaluated and written back when the beat advances, with the last write
// forwarded to a following read of the same entry. A beat passes the
// stage-one and output registers before its result is valid. After reset
// the entry memory is swept clear one entry per cycle; input stall is high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module transposition_table_probe_store
    import ttps_pkg::*;
#(
    parameter int unsigned INDEX_BITS = 16,
    parameter int unsigned DEPTH_BITS = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_operation,
    input  wire logic [31:0]         i_hash_low,
    input  wire logic [63:0]         i_hash_check,
    input  wire logic [3:0]          i_search_depth,
    input  wire logic signed [31:0]  i_alpha,
    input  wire logic signed [31:0]  i_beta,
    input  wire logic [1:0]          i_bound_kind,
    input  wire logic signed [31:0]  i_store_eval,
    input  wire logic [23:0]         i_move_code,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_key_match,
    output logic                     o_score_usable,
    output logic signed [31:0]       o_score,
    output logic [23:0]              o_hint_move,
    output logic                     o_store_done
);

    localparam int unsigned CW = (DEPTH_BITS > ASK_W) ? DEPTH_BITS : ASK_W;
    localparam logic [CW-1:0] DEPTH_MAX = CW'({DEPTH_BITS{1'b1}});

    logic                  r_s1_vld;
    t_op                   r_s1_op;
    logic [INDEX_BITS-1:0] r_s1_idx;
    logic [63:0]           r_s1_check;
    logic [ASK_W-1:0]      r_s1_depth;
    logic signed [31:0]    r_s1_alpha;
    logic signed [31:0]    r_s1_beta;
    t_bound                r_s1_kind;
    logic [SCORE_W-1:0]    r_s1_eval;
    logic [MOVE_W-1:0]     r_s1_move;

    logic                  r_out_vld;
    logic                  r_key_match;
    logic                  r_score_usable;
    logic signed [31:0]    r_score;
    logic [MOVE_W-1:0]     r_hint_move;
    logic                  r_store_done;

    logic                  n_key_match;
    logic                  n_score_usable;
    logic signed [31:0]    n_score;
    logic [MOVE_W-1:0]     n_hint_move;
    logic                  n_store_done;

    logic                  accept;
    logic                  advance;
    logic                  busy;
    logic [63:0]           rd_tag;
    t_slot                 rd_slot;
    logic [DEPTH_BITS-1:0] rd_depth;
    logic                  wr_en;
    t_slot                 wr_slot;
    logic [DEPTH_BITS-1:0] wr_depth;

    assign advance    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = busy || (r_s1_vld && !advance);
    assign accept     = i_in_valid && !o_in_stall;

    ttps_table #(
        .INDEX_BITS (INDEX_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_idx   (i_hash_low[INDEX_BITS-1:0]),
        .i_wr_en    (wr_en),
        .i_wr_idx   (r_s1_idx),
        .i_wr_tag   (r_s1_check),
        .i_wr_slot  (wr_slot),
        .i_wr_depth (wr_depth),
        .o_rd_tag   (rd_tag),
        .o_rd_slot  (rd_slot),
        .o_rd_depth (rd_depth),
        .o_busy     (busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= i_operation;
            r_s1_idx   <= i_hash_low[INDEX_BITS-1:0];
            r_s1_check <= i_hash_check;
            r_s1_depth <= i_search_depth;
            r_s1_alpha <= i_alpha;
            r_s1_beta  <= i_beta;
            r_s1_kind  <= i_bound_kind;
            r_s1_eval  <= i_store_eval;
            r_s1_move  <= i_move_code;
        end
    end

    always_comb begin
        logic [CW-1:0] stored_d;
        logic [CW-1:0] asked_d;
        logic [CW-1:0] sat_d;
        logic          hit;
        logic          usable;
        logic          keep_ok;

        stored_d = CW'(rd_depth);
        asked_d  = CW'(r_s1_depth);
        sat_d    = (asked_d > DEPTH_MAX) ? DEPTH_MAX : asked_d;
        hit      = rd_slot.valid && (rd_tag == r_s1_check);
        usable   = 1'b0;
        if (stored_d >= asked_d) begin
            case (rd_slot.kind)
                BOUND_EXACT: usable = 1'b1;
                BOUND_LOWER: usable = ($signed(rd_slot.score) >= r_s1_beta);
                BOUND_UPPER: usable = ($signed(rd_slot.score) <= r_s1_alpha);
                default:     usable = 1'b0;
            endcase
        end
        keep_ok = !(rd_slot.valid && (stored_d > sat_d));

        wr_slot.valid = 1'b1;
        wr_slot.kind  = r_s1_kind;
        wr_slot.score = r_s1_eval;
        wr_slot.move  = r_s1_move;
        wr_depth      = sat_d[DEPTH_BITS-1:0];
        wr_en         = advance && (r_s1_op == OP_STORE) && keep_ok;

        n_key_match    = 1'b0;
        n_score_usable = 1'b0;
        n_score        = '0;
        n_hint_move    = '0;
        n_store_done   = 1'b0;
        if (r_s1_op == OP_PROBE) begin
            if (hit) begin
                n_key_match = 1'b1;
                n_hint_move = rd_slot.move;
                if (usable) begin
                    n_score_usable = 1'b1;
                    n_score        = $signed(rd_slot.score);
                end
            end
        end else begin
            n_store_done = keep_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_key_match    <= n_key_match;
            r_score_usable <= n_score_usable;
            r_score        <= n_score;
            r_hint_move    <= n_hint_move;
            r_store_done   <= n_store_done;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_key_match    = r_key_match;
    assign o_score_usable = r_score_usable;
    assign o_score        = r_score;
    assign o_hint_move    = r_hint_move;
    assign o_store_done   = r_store_done;

    `ASSERT_RST(a_stall_in_clear, i_clk, i_rst_n, busy |-> o_in_stall)
    `ASSERT_RST(a_write_on_store, i_clk, i_rst_n, wr_en |-> (advance && r_s1_op == OP_STORE))
    `ASSERT_RST(a_usable_needs_hit, i_clk, i_rst_n, (o_out_valid && o_score_usable) |-> o_key_match)
    `ASSERT_RST(a_probe_or_store, i_clk, i_rst_n, o_out_valid |-> !(o_store_done && o_key_match))

endmodule
`default_nettype wire

/* rtl/core/ttps_table.sv */
// Tag and entry memories with clearing pass and write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ttps_table
    import ttps_pkg::*;
#(
    parameter int unsigned INDEX_BITS = 16,
    parameter int unsigned DEPTH_BITS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [INDEX_BITS-1:0] i_rd_idx,
    input  wire logic                  i_wr_en,
    input  wire logic [INDEX_BITS-1:0] i_wr_idx,
    input  wire logic [63:0]           i_wr_tag,
    input  wire t_slot                 i_wr_slot,
    input  wire logic [DEPTH_BITS-1:0] i_wr_depth,
    output logic [63:0]                o_rd_tag,
    output t_slot                      o_rd_slot,
    output logic [DEPTH_BITS-1:0]      o_rd_depth,
    output logic                       o_busy
);

    localparam int unsigned ENTRIES = 1 << INDEX_BITS;
    localparam int unsigned EW      = DEPTH_BITS + SLOT_W;

    logic [EW-1:0]         r_entry_mem [0:ENTRIES-1];
    logic [63:0]           r_tag_mem   [0:ENTRIES-1];
    logic [EW-1:0]         r_ent_q;
    logic [63:0]           r_tag_q;
    logic [INDEX_BITS-1:0] r_rd_idx;

    logic                  r_clr_busy;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic [INDEX_BITS-1:0] n_clr_idx;

    logic                  r_fwd_vld;
    logic [INDEX_BITS-1:0] r_fwd_idx;
    logic [63:0]           r_fwd_tag;
    logic [EW-1:0]         r_fwd_ent;

    logic                  fwd_hit;
    logic [EW-1:0]         rd_word;

    assign n_clr_idx = r_clr_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_fwd_vld  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= n_clr_idx;
                if (&r_clr_idx) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_wr_en && !r_clr_busy) begin
                r_fwd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_entry_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_entry_mem[i_wr_idx] <= {i_wr_depth, i_wr_slot};
        end
        if (i_wr_en && !r_clr_busy) begin
            r_tag_mem[i_wr_idx] <= i_wr_tag;
            r_fwd_idx           <= i_wr_idx;
            r_fwd_tag           <= i_wr_tag;
            r_fwd_ent           <= {i_wr_depth, i_wr_slot};
        end
        if (i_rd_en) begin
            r_ent_q  <= r_entry_mem[i_rd_idx];
            r_tag_q  <= r_tag_mem[i_rd_idx];
            r_rd_idx <= i_rd_idx;
        end
    end

    // read and write share an edge: newest write wins over stale read data
    assign fwd_hit    = r_fwd_vld && (r_fwd_idx == r_rd_idx);
    assign rd_word    = fwd_hit ? r_fwd_ent : r_ent_q;
    assign o_rd_tag   = fwd_hit ? r_fwd_tag : r_tag_q;
    assign o_rd_slot  = t_slot'(rd_word[SLOT_W-1:0]);
    assign o_rd_depth = rd_word[EW-1:SLOT_W];
    assign o_busy     = r_clr_busy;

    `ASSERT_RST(a_no_write_in_clear, i_clk, i_rst_n, r_clr_busy |-> !i_wr_en)
    `ASSERT_RST(a_fwd_after_write, i_clk, i_rst_n, (i_wr_en && !r_clr_busy) |=> r_fwd_vld)
    `ASSERT_RST(a_no_read_in_clear, i_clk, i_rst_n, r_clr_busy |-> !i_rd_en)

endmodule
`default_nettype wire
